/* rtl/ps2sc_pkg.sv */
// shared types, constants and key maps for the ps/2 set 1 scancode translator
// no dependencies; imported by every module of the block but ps2sc_ram
package ps2sc_pkg;

  // default ring buffer depth (holds one fewer character than this)
  localparam int DEF_BUFFER_DEPTH = 64;

  // depth of the result queue in the back part
  localparam int OUT_DEPTH = 4;

  // depth of the op queue between front and back
  localparam int OP_DEPTH = 2;

  // scancodes with a meaning of their own
  localparam logic [7:0] KEY_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] KEY_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] KEY_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] KEY_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] KEY_CAPS_MAKE    = 8'h3A;
  localparam logic [7:0] KEY_BREAK_BIT    = 8'h80;
  localparam logic [7:0] KEY_PREFIX_E0    = 8'hE0;
  localparam logic [7:0] KEY_PREFIX_E1    = 8'hE1;
  localparam int         KEY_MAPPED       = 58;

  // input item and result item
  typedef struct packed {
    logic       kind;
    logic [7:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] read_char;
    logic       has_input;
    logic       dropped;
  } out_item_t;

  // item kinds on the input channel
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // classified work handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_PUSH
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [6:0] ch;
  } op_t;

  // unshifted key map
  localparam logic [6:0] LOWER_MAP [KEY_MAPPED] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // shifted key map
  localparam logic [6:0] UPPER_MAP [KEY_MAPPED] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // map a make code to ascii, zero for unmapped keys
  function automatic logic [6:0] key_lookup(input logic [7:0] code, input logic upper);
    logic [6:0] ch;
    ch = '0;
    if (code < 8'(KEY_MAPPED)) begin
      if (upper) begin
        ch = UPPER_MAP[code[5:0]];
      end else begin
        ch = LOWER_MAP[code[5:0]];
      end
    end
    return ch;
  endfunction

endpackage

/* rtl/ps2sc_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ps2sc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ps2sc_front.sv */
// front part: accepts items, tracks shift and caps, translates scancodes
// into ops and queues them for the back part; depends on ps2sc_pkg
module ps2sc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ps2sc_pkg::in_item_t in_item,
  output logic                op_valid,
  input  logic                op_ready,
  output ps2sc_pkg::op_t      op
);

  import ps2sc_pkg::*;

  localparam int IW = $clog2(OP_DEPTH);
  localparam int CW = $clog2(OP_DEPTH + 1);

  logic     shift_flag, shift_flag_next;
  logic     caps_flag, caps_flag_next;
  op_t      op_in;
  op_t      queue [OP_DEPTH];
  logic [IW-1:0] head, tail;
  logic [CW-1:0] count;
  logic     accept, take;
  logic [6:0] ch;

  assign full     = (count == CW'(OP_DEPTH));
  assign accept   = push && !full;
  assign op_valid = (count != '0);
  assign take     = op_valid && op_ready;
  assign op       = queue[head];

  // classify the incoming item and update the modifier flags
  always_comb begin
    shift_flag_next = shift_flag;
    caps_flag_next  = caps_flag;
    op_in.kind      = OP_NONE;
    op_in.ch        = '0;
    ch              = key_lookup(in_item.scan_byte, shift_flag ^ caps_flag);
    if (in_item.kind == KIND_READ) begin
      op_in.kind = OP_READ;
    end else if (in_item.scan_byte == KEY_LSHIFT_MAKE ||
                 in_item.scan_byte == KEY_RSHIFT_MAKE) begin
      shift_flag_next = 1'b1;
    end else if (in_item.scan_byte == KEY_LSHIFT_BREAK ||
                 in_item.scan_byte == KEY_RSHIFT_BREAK) begin
      shift_flag_next = 1'b0;
    end else if (in_item.scan_byte == KEY_CAPS_MAKE) begin
      caps_flag_next = ~caps_flag;
    end else if ((in_item.scan_byte & KEY_BREAK_BIT) == '0) begin
      // break codes and the e0 / e1 prefixes fall through as no-ops
      if (ch != '0) begin
        op_in.kind = OP_PUSH;
        op_in.ch   = ch;
      end
    end
  end

  // modifier flags and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag <= 1'b0;
      caps_flag  <= 1'b0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        shift_flag <= shift_flag_next;
        caps_flag  <= caps_flag_next;
        tail       <= (tail == IW'(OP_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (take) begin
        head <= (head == IW'(OP_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (accept && !take) begin
        count <= count + 1'b1;
      end else if (take && !accept) begin
        count <= count - 1'b1;
      end
    end
  end

  // op queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      queue[tail] <= op_in;
    end
  end

endmodule

/* rtl/ps2sc_back.sv */
// back part: character ring buffer, read and push execution, result queue
// depends on ps2sc_pkg and ps2sc_ram
module ps2sc_back #(
  parameter int BUFFER_DEPTH = ps2sc_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  ps2sc_pkg::op_t       op,
  output logic                 empty,
  input  logic                 pop,
  output ps2sc_pkg::out_item_t out_item
);

  import ps2sc_pkg::*;

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam int OW = $clog2(OUT_DEPTH);
  localparam int OC = $clog2(OUT_DEPTH + 1);

  logic [PW-1:0] wr_ptr, wr_ptr_next, wr_inc;
  logic [PW-1:0] rd_ptr, rd_ptr_next, rd_inc;
  logic          take, we, re, hit, drop;
  logic [6:0]    rdata;

  // execute stage outputs
  logic          s1_valid, s1_hit, s1_has, s1_drop;

  // result queue
  out_item_t     res_q [OUT_DEPTH];
  out_item_t     res;
  logic [OW-1:0] oq_head, oq_tail;
  logic [OC-1:0] oq_count;
  logic          oq_pop;

  // reserve a result slot for the item in flight
  assign op_ready = ((oq_count + OC'(s1_valid)) < OC'(OUT_DEPTH));
  assign take     = op_valid && op_ready;

  assign wr_inc = (wr_ptr == PW'(BUFFER_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == PW'(BUFFER_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // pointer update and memory access for one op
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    we          = 1'b0;
    re          = 1'b0;
    hit         = 1'b0;
    drop        = 1'b0;
    if (take) begin
      unique case (op.kind)
        OP_READ: begin
          if (wr_ptr != rd_ptr) begin
            hit         = 1'b1;
            re          = 1'b1;
            rd_ptr_next = rd_inc;
          end
        end
        OP_PUSH: begin
          if (wr_inc == rd_ptr) begin
            drop = 1'b1;
          end else begin
            we          = 1'b1;
            wr_ptr_next = wr_inc;
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  ps2sc_ram #(
    .WIDTH (7),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wr_ptr),
    .wdata (op.ch),
    .re    (re),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  // pointers and execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      s1_valid <= 1'b0;
    end else begin
      wr_ptr   <= wr_ptr_next;
      rd_ptr   <= rd_ptr_next;
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    s1_hit  <= hit;
    s1_has  <= (wr_ptr_next != rd_ptr_next);
    s1_drop <= drop;
  end

  // assemble the result once the read data is back
  always_comb begin
    res.read_char = s1_hit ? rdata : '0;
    res.has_input = s1_has;
    res.dropped   = s1_drop;
  end

  assign empty    = (oq_count == '0);
  assign oq_pop   = pop && !empty;
  assign out_item = res_q[oq_head];

  // result queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head  <= '0;
      oq_tail  <= '0;
      oq_count <= '0;
    end else begin
      if (s1_valid) begin
        oq_tail <= (oq_tail == OW'(OUT_DEPTH - 1)) ? '0 : oq_tail + 1'b1;
      end
      if (oq_pop) begin
        oq_head <= (oq_head == OW'(OUT_DEPTH - 1)) ? '0 : oq_head + 1'b1;
      end
      if (s1_valid && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (oq_pop && !s1_valid) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      res_q[oq_tail] <= res;
    end
  end

endmodule

/* rtl/ps2sc_scancode_to_ascii_fifo.sv */
// top level of the ps/2 set 1 scancode to ascii translator with receive buffer
// depends on ps2sc_pkg, ps2sc_front and ps2sc_back
//
// Takes one item per clock while full is low: either a set 1 scancode byte
// or a request to read one character, and returns exactly one result item
// for each, in order. Shift make and break codes and caps lock drive the
// case of the translation; translated characters go into a ring buffer of
// BUFFER_DEPTH slots that holds up to BUFFER_DEPTH - 1 characters, and a
// character that finds it full is dropped and flagged. A result passes
// through the op queue, then the execute stage with the buffer memory's
// registered read, then the result queue before it shows on out_item.
// Sustained rate is one item per cycle as long as results are popped; the
// front holds two ops and the result queue four, so full rises only when the
// result side has stalled. The buffer memory needs no clearing after reset.
module ps2_scancode_to_ascii_fifo #(
  parameter int BUFFER_DEPTH = ps2sc_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ps2sc_pkg::in_item_t  in_item,
  output logic                 empty,
  input  logic                 pop,
  output ps2sc_pkg::out_item_t out_item
);

  import ps2sc_pkg::*;

  logic op_valid;
  logic op_ready;
  op_t  op;

  ps2sc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  ps2sc_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
